[rtl/pme_pkg.sv]
// Package for the polynomial map evaluator: payload types, codes and constants.
`default_nettype none
package pme_pkg;
   localparam int NCOORD       = 6;
   localparam int FACTOR_SLOTS = 8;
   localparam int VAL_W        = 48;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_TRANSFORM = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DECODE,
      ST_MUL,
      ST_QUANT,
      ST_ADD,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [2:0]         component;
      logic [3:0]         degree;
      logic [23:0]        factor_list;
      logic signed [47:0] coefficient;
      logic signed [47:0] x0;
      logic signed [47:0] x1;
      logic signed [47:0] x2;
      logic signed [47:0] x3;
      logic signed [47:0] x4;
      logic signed [47:0] x5;
   } req_type;

   typedef struct packed {
      logic signed [47:0] y0;
      logic signed [47:0] y1;
      logic signed [47:0] y2;
      logic signed [47:0] y3;
      logic signed [47:0] y4;
      logic signed [47:0] y5;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic [23:0] factor_list;
      logic [3:0]  degree;
      logic [2:0]  component;
   } desc_type;
endpackage
`default_nettype wire

[rtl/polynomial_map_evaluator_core.sv]
// Top level of the polynomial map evaluator: term table, sequencer and arithmetic.
`default_nettype none
// Evaluates a six-coordinate polynomial map on one particle item at a time.
// Load items append a term (component, degree, factor indices, coefficient) to
// a term table held in two memories, each with one write and one read port
// (registered read); a clear item empties the table and loads beyond
// MAX_TERMS are dropped. Loads and clears give no result. A transform item
// walks every stored term: ST_READ fetches and ST_DECODE decodes each term.
// For terms that are evaluated, each 48x48 Q-format multiply per factor is
// done in ST_MUL as three 48x16 partial products into a wide register, then
// rounded toward minus infinity and clamped in ST_QUANT; ST_ADD then adds the
// term into the coordinate accumulator. When all stored terms are done, the
// result register is loaded once it is free; the next item is taken while
// that result still waits. Outputs are clamped to 48 bits and saturated flags
// any clamp. req_stall is held high during reset. The user must write
// map_order through csr_ only while the block is idle; the block itself does
// not enforce it.
module polynomial_map_evaluator_core
   import pme_pkg::*;
#(
   parameter int MAX_TERMS = 256,
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_enable,
   input  wire logic [3:0] csr_write_data
);
   localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam int ACC_W = VAL_W + AW + 1;
   localparam int PW    = 2 * VAL_W;

   localparam logic [PW-1:0] POS_LIM = PW'(48'h7FFF_FFFF_FFFF);
   localparam logic [PW-1:0] NEG_LIM = PW'(48'h8000_0000_0000);
   localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(48'sh7FFF_FFFF_FFFF);
   localparam logic signed [ACC_W-1:0] ACC_MIN = -(ACC_W'(48'sh7FFF_FFFF_FFFF)) - 1;

   // term table
   logic [VAL_W-1:0] coeff_mem [MAX_TERMS];
   desc_type         desc_mem  [MAX_TERMS];
   logic [VAL_W-1:0] coeff_rd_ff;
   desc_type         desc_rd_ff;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] t_ff, t_in;
   logic [3:0] map_order_ff;
   logic signed [VAL_W-1:0] x_ff [NCOORD];
   logic signed [VAL_W-1:0] x_in [NCOORD];
   logic signed [ACC_W-1:0] acc_ff [NCOORD];
   logic signed [ACC_W-1:0] acc_in [NCOORD];
   logic signed [VAL_W-1:0] term_ff, term_in;
   logic [2:0]  comp_ff, comp_in;
   logic [3:0]  deg_ff, deg_in;
   logic [3:0]  k_ff, k_in;
   logic [23:0] flist_ff, flist_in;
   logic [1:0]  chunk_ff, chunk_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic sat_ff, sat_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic req_take, load_we;
   logic signed [VAL_W-1:0] xsel;
   logic [VAL_W-1:0] ma, mb;
   logic [15:0] mb_part;
   logic [63:0] part;
   logic neg;
   logic [PW-1:0] q_full, q_adj;
   logic rem;
   logic skip;
   logic signed [VAL_W-1:0] y_cl [NCOORD];
   logic y_sat;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign load_we   = req_take && (req_data.op == OP_LOAD)
                      && (count_ff < CNT_W'(MAX_TERMS));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (load_we) begin
         coeff_mem[count_ff[AW-1:0]] <= req_data.coefficient;
         desc_mem[count_ff[AW-1:0]]  <= '{factor_list: req_data.factor_list,
                                          degree: req_data.degree,
                                          component: req_data.component};
      end
      coeff_rd_ff <= coeff_mem[t_ff[AW-1:0]];
      desc_rd_ff  <= desc_mem[t_ff[AW-1:0]];
   end

   // multiply datapath
   always_comb begin
      case (flist_ff[2:0])
         3'd0:    xsel = x_ff[0];
         3'd1:    xsel = x_ff[1];
         3'd2:    xsel = x_ff[2];
         3'd3:    xsel = x_ff[3];
         3'd4:    xsel = x_ff[4];
         3'd5:    xsel = x_ff[5];
         default: xsel = '0;
      endcase
      ma  = term_ff[VAL_W-1] ? (VAL_W'(0) - term_ff) : term_ff;
      mb  = xsel[VAL_W-1] ? (VAL_W'(0) - xsel) : xsel;
      neg = term_ff[VAL_W-1] ^ xsel[VAL_W-1];
      case (chunk_ff)
         2'd0:    mb_part = mb[15:0];
         2'd1:    mb_part = mb[31:16];
         default: mb_part = mb[47:32];
      endcase
      part   = 64'(ma) * 64'(mb_part);
      q_full = prod_ff >> FRAC_BITS;
      rem    = |prod_ff[FRAC_BITS-1:0];
      q_adj  = q_full + PW'(rem);
      skip   = (desc_rd_ff.component >= 3'(NCOORD))
               || (desc_rd_ff.degree > map_order_ff)
               || (32'(desc_rd_ff.degree) > MAX_ORDER)
               || (32'(desc_rd_ff.degree) > FACTOR_SLOTS);
   end

   // output clamp
   always_comb begin
      y_sat = 1'b0;
      for (int c = 0; c < NCOORD; c++) begin
         if (acc_ff[c] > ACC_MAX) begin
            y_cl[c] = 48'sh7FFF_FFFF_FFFF;
            y_sat   = 1'b1;
         end else if (acc_ff[c] < ACC_MIN) begin
            y_cl[c] = 48'sh8000_0000_0000;
            y_sat   = 1'b1;
         end else begin
            y_cl[c] = acc_ff[c][VAL_W-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      t_in         = t_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      comp_in      = comp_ff;
      deg_in       = deg_ff;
      k_in         = k_ff;
      flist_in     = flist_ff;
      chunk_in     = chunk_ff;
      prod_in      = prod_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_data.op)
                  OP_LOAD: begin
                     if (load_we) count_in = count_ff + 1'b1;
                  end
                  OP_CLEAR: count_in = '0;
                  OP_TRANSFORM: begin
                     x_in[0] = req_data.x0;
                     x_in[1] = req_data.x1;
                     x_in[2] = req_data.x2;
                     x_in[3] = req_data.x3;
                     x_in[4] = req_data.x4;
                     x_in[5] = req_data.x5;
                     for (int c = 0; c < NCOORD; c++) acc_in[c] = '0;
                     sat_in   = 1'b0;
                     t_in     = '0;
                     state_in = (count_ff == '0) ? ST_FINAL : ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_DECODE;
         ST_DECODE: begin
            term_in  = coeff_rd_ff;
            comp_in  = desc_rd_ff.component;
            deg_in   = desc_rd_ff.degree;
            flist_in = desc_rd_ff.factor_list;
            k_in     = '0;
            chunk_in = '0;
            prod_in  = '0;
            if (skip) begin
               t_in     = t_ff + 1'b1;
               state_in = (t_ff + 1'b1 == count_ff) ? ST_FINAL : ST_READ;
            end else if (desc_rd_ff.degree == '0) begin
               state_in = ST_ADD;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            case (chunk_ff)
               2'd0:    prod_in = prod_ff + PW'(part);
               2'd1:    prod_in = prod_ff + (PW'(part) << 16);
               default: prod_in = prod_ff + (PW'(part) << 32);
            endcase
            if (chunk_ff == 2'd2) state_in = ST_QUANT;
            else chunk_in = chunk_ff + 1'b1;
         end
         ST_QUANT: begin
            if (!neg) begin
               if (q_full > POS_LIM) begin
                  term_in = 48'sh7FFF_FFFF_FFFF;
                  sat_in  = 1'b1;
               end else begin
                  term_in = q_full[VAL_W-1:0];
               end
            end else begin
               if (q_adj > NEG_LIM) begin
                  term_in = 48'sh8000_0000_0000;
                  sat_in  = 1'b1;
               end else begin
                  term_in = VAL_W'(0) - q_adj[VAL_W-1:0];
               end
            end
            flist_in = flist_ff >> 3;
            k_in     = k_ff + 1'b1;
            chunk_in = '0;
            prod_in  = '0;
            state_in = (k_ff + 1'b1 == deg_ff) ? ST_ADD : ST_MUL;
         end
         ST_ADD: begin
            acc_in[comp_ff] = acc_ff[comp_ff] + ACC_W'(term_ff);
            t_in     = t_ff + 1'b1;
            state_in = (t_ff + 1'b1 == count_ff) ? ST_FINAL : ST_READ;
         end
         ST_FINAL: begin
            // wait for the result register to be free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{y0: y_cl[0], y1: y_cl[1], y2: y_cl[2],
                                y3: y_cl[3], y4: y_cl[4], y5: y_cl[5],
                                saturated: sat_ff || y_sat};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         map_order_ff <= 4'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) map_order_ff <= csr_write_data;
      end
      t_ff        <= t_in;
      x_ff        <= x_in;
      acc_ff      <= acc_in;
      term_ff     <= term_in;
      comp_ff     <= comp_in;
      deg_ff      <= deg_in;
      k_ff        <= k_in;
      flist_ff    <= flist_in;
      chunk_ff    <= chunk_in;
      prod_ff     <= prod_in;
      sat_ff      <= sat_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TERMS))
      else $error("term count beyond table size");
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (t_ff < count_ff))
      else $error("term fetch beyond stored terms");
   a_transform_busy: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.op == OP_TRANSFORM) |=> (state_ff != ST_IDLE))
      else $error("transform item did not start");
   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (chunk_ff <= 2'd2))
      else $error("partial product step out of range");
endmodule
`default_nettype wire

[sim/tb_polynomial_map_evaluator_core.sv]
// Self-checking testbench for the polynomial map evaluator core.
`default_nettype none
module tb_polynomial_map_evaluator_core;
   import pme_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  TABLE_DEPTH = 256;
   localparam int  ORDER_CAP   = 8;
   localparam int  CYCLE_LIMIT = 8_000_000;
   localparam logic signed [47:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] Q_MIN = 48'sh8000_0000_0000;
   localparam logic signed [47:0] Q_ONE = 48'sh0001_0000_0000;

   // Directed rows: typed_exp marks rows whose result is written out by hand.
   typedef struct {
      req_type item;
      bit      typed_exp;
      rsp_type exp;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_write_enable;
   logic [3:0] csr_write_data;

   polynomial_map_evaluator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the term table and of map_order.
   logic [2:0]         term_comp  [TABLE_DEPTH];
   logic [3:0]         term_deg   [TABLE_DEPTH];
   logic [23:0]        term_flist [TABLE_DEPTH];
   logic signed [47:0] term_coef  [TABLE_DEPTH];
   int unsigned        term_count;
   logic [3:0]         map_order;

   rsp_type          mapped_q[$];   // coordinates still owed by the block
   directed_row_type dir_rows[$];
   int unsigned n_items, n_results, n_mismatch, n_sat, n_full_drops, cycles;
   bit          orders_seen[16];

   always #5 clock = ~clock;

   // Cycle counter doubles as the watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, mapped_q.size());
         $display("tb_polynomial_map_evaluator_core NOT OK");
         $finish;
      end
   end

   // Receiver stall pattern: free-running, random-thin, or long on/off runs,
   // each picked at random.
   int unsigned stall_mode, stall_run, stall_tick;
   always @(negedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (stall_run == 0) begin
               stall_run <= $urandom_range(1, 20);
               rsp_stall <= ~rsp_stall;
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   // Q15.32 multiply: full product, floor by dropping the fraction, clamp.
   function automatic logic signed [47:0] q_mul(input logic signed [47:0] a,
                                                input logic signed [47:0] b,
                                                inout bit sat);
      logic signed [95:0] prod;
      logic signed [63:0] shifted;
      prod    = $signed({{48{a[47]}}, a}) * $signed({{48{b[47]}}, b});
      shifted = $signed(prod[95:32]);
      if (shifted > 64'(Q_MAX)) begin
         sat = 1'b1;
         return Q_MAX;
      end
      if (shifted < 64'(Q_MIN)) begin
         sat = 1'b1;
         return Q_MIN;
      end
      return shifted[47:0];
   endfunction

   function automatic rsp_type map_particle(input req_type p);
      logic signed [47:0] xs[NCOORD];
      longint             acc[NCOORD];
      logic signed [47:0] term, clamped[NCOORD];
      logic [2:0]         idx;
      bit                 sat;
      rsp_type            r;
      xs = '{p.x0, p.x1, p.x2, p.x3, p.x4, p.x5};
      sat = 1'b0;
      foreach (acc[c]) acc[c] = 0;
      for (int t = 0; t < term_count; t++) begin
         // components six and seven, or degrees past the order or past eight, add nothing
         if (term_comp[t] >= NCOORD || term_deg[t] > map_order || term_deg[t] > ORDER_CAP)
            continue;
         term = term_coef[t];
         for (int k = 0; k < term_deg[t]; k++) begin
            idx  = term_flist[t][3*k +: 3];
            term = q_mul(term, (idx < NCOORD) ? xs[idx] : 48'sd0, sat);
         end
         acc[term_comp[t]] += longint'(term);
      end
      foreach (acc[c]) begin
         if (acc[c] > longint'(Q_MAX)) begin
            clamped[c] = Q_MAX;
            sat = 1'b1;
         end else if (acc[c] < longint'(Q_MIN)) begin
            clamped[c] = Q_MIN;
            sat = 1'b1;
         end else begin
            clamped[c] = acc[c][47:0];
         end
      end
      r.y0 = clamped[0]; r.y1 = clamped[1]; r.y2 = clamped[2];
      r.y3 = clamped[3]; r.y4 = clamped[4]; r.y5 = clamped[5];
      r.saturated = sat;
      return r;
   endfunction

   // Apply one accepted item to the shadow state; transforms queue a result.
   task automatic absorb_item(input req_type it, input bit typed_exp, input rsp_type exp);
      rsp_type r;
      n_items++;
      case (op_type'(it.op))
         OP_LOAD: begin
            if (term_count < TABLE_DEPTH) begin
               term_comp[term_count]  = it.component;
               term_deg[term_count]   = it.degree;
               term_flist[term_count] = it.factor_list;
               term_coef[term_count]  = it.coefficient;
               term_count++;
            end else begin
               n_full_drops++;
            end
         end
         OP_CLEAR: term_count = 0;
         OP_TRANSFORM: begin
            r = map_particle(it);
            mapped_q.insert(mapped_q.size(), typed_exp ? exp : r);
         end
         default: ;
      endcase
   endtask

   // Drive one item from the falling edge and hold it until accepted.
   task automatic send_item(input req_type it, input bit typed_exp = 0,
                            input rsp_type exp = '0);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!(req_valid && !req_stall));
      absorb_item(it, typed_exp, exp);
   endtask

   task automatic idle_gap(input int unsigned n);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= '{default: '1};
      repeat (n) @(negedge clock);
   endtask

   // Register write while idle: drain results, then allow for a trailing load.
   task automatic write_map_order(input logic [3:0] val);
      idle_gap(0);
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data   <= 4'($urandom_range(0, 15));
      map_order = val;
      orders_seen[val] = 1'b1;
   endtask

   // Result checker: oldest expectation first, every field compared.
   always @(posedge clock) begin
      rsp_type exp;
      logic signed [47:0] gy[NCOORD], ey[NCOORD];
      bit bad;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mapped_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected result item: %p", rsp_data);
         end else begin
            exp = mapped_q.pop_front();
            n_results++;
            if (exp.saturated) n_sat++;
            gy = '{rsp_data.y0, rsp_data.y1, rsp_data.y2, rsp_data.y3, rsp_data.y4, rsp_data.y5};
            ey = '{exp.y0, exp.y1, exp.y2, exp.y3, exp.y4, exp.y5};
            bad = (rsp_data.saturated !== exp.saturated);
            foreach (gy[c]) if (gy[c] !== ey[c]) bad = 1'b1;
            if (bad) begin
               n_mismatch++;
               if (n_mismatch <= 10) begin
                  $display("mismatch on result %0d at cycle %0d:", n_results, cycles);
                  foreach (gy[c])
                     $display("  y%0d exp %h got %h", c, ey[c], gy[c]);
                  $display("  saturated exp %b got %b", exp.saturated, rsp_data.saturated);
               end
            end
         end
      end
   end

   function automatic logic signed [47:0] rand_q(input int unsigned style);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case (style)
         0: return $signed({{13{r[34]}}, r[34:0]});   // within +/-4.0
         1: return $signed({{17{r[30]}}, r[30:0]});   // within +/-0.25
         2: return ($urandom_range(0, 1) != 0) ? Q_MAX : Q_MIN;
         default: return r[47:0];
      endcase
   endfunction

   function automatic req_type mk_term(input logic [2:0] comp, input logic [3:0] deg,
                                       input logic [23:0] flist,
                                       input logic signed [47:0] coef);
      req_type it;
      it = '0;
      it.op = OP_LOAD;
      it.component = comp;
      it.degree = deg;
      it.factor_list = flist;
      it.coefficient = coef;
      return it;
   endfunction

   function automatic req_type mk_particle(input logic signed [47:0] a0, a1, a2, a3, a4, a5);
      req_type it;
      it = '0;
      it.op = OP_TRANSFORM;
      it.x0 = a0; it.x1 = a1; it.x2 = a2; it.x3 = a3; it.x4 = a4; it.x5 = a5;
      return it;
   endfunction

   function automatic req_type rand_term(input int unsigned max_deg);
      logic [2:0] comp;
      logic [3:0] deg;
      comp = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                          : 3'($urandom_range(0, 5));
      deg  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, max_deg));
      // factor indices six and seven show up now and then
      return mk_term(comp, deg, ($urandom_range(0, 3) == 0) ? 24'($urandom)
                                 : 24'($urandom) & 24'o33333333 | 24'($urandom) & 24'o44444444
                                   & {8{3'($urandom_range(0, 1) << 2)}},
                     rand_q($urandom_range(0, 3)));
   endfunction

   function automatic req_type rand_particle();
      int unsigned s;
      s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
      return mk_particle(rand_q(s), rand_q(s), rand_q(s), rand_q(s), rand_q(s), rand_q(s));
   endfunction

   // Random items with sender bursts and gaps.
   int unsigned burst_left;
   task automatic send_random(input req_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 15));
      end
      burst_left--;
      send_item(it);
   endtask

   task automatic add_row(input directed_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic build_directed();
      directed_row_type row;
      rsp_type          z;
      z = '0;
      // empty table after reset maps everything to zero
      row = '{mk_particle(Q_MAX, Q_MIN, Q_ONE, -Q_ONE, 48'sd7, -48'sd7), 1, z};
      add_row(row);
      add_row('{mk_term(3'd0, 4'd1, 24'o0, Q_ONE), 0, z});
      add_row('{mk_term(3'd5, 4'd0, 24'o0, Q_MAX), 0, z});
      row = '{mk_particle(48'sh3_0000_0000, '0, '0, '0, '0, '0), 1, z};
      row.exp.y0 = 48'sh3_0000_0000;
      row.exp.y5 = Q_MAX;
      add_row(row);
      // factor index seven reads as zero
      add_row('{mk_term(3'd1, 4'd1, 24'o7, -48'sd1), 0, z});
      // component six is stored but feeds nothing
      add_row('{mk_term(3'd6, 4'd0, 24'o0, 48'sd5), 0, z});
      add_row('{mk_term(3'd2, 4'd1, 24'o1, Q_MIN), 0, z});
      // most negative coefficient times largest coordinate clamps
      row = '{mk_particle('0, Q_MAX, '0, '0, '0, '0), 1, z};
      row.exp.y2 = Q_MIN;
      row.exp.y5 = Q_MAX;
      row.exp.saturated = 1'b1;
      add_row(row);
      // degree beyond the factor slots is never evaluated
      add_row('{mk_term(3'd3, 4'd15, 24'hFF_FFFF, Q_ONE), 0, z});
      add_row('{mk_term(3'd4, 4'd2, 24'o54, -Q_ONE), 0, z});
      add_row('{mk_term(3'd7, 4'd8, 24'o0, Q_MAX), 0, z});
      add_row('{mk_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 0, z});
      add_row('{mk_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 0, z});
      // unused op with every field bit set
      row = '{'1, 0, z};
      row.item.op = OP_UNUSED;
      add_row(row);
      add_row('{mk_particle(48'shAAAA_AAAA_AAAA, 48'sh5555_5555_5555, Q_ONE,
                            -Q_ONE, 48'sh0000_8000_0000, 48'sd1), 0, z});
      row = '{'0, 0, z};
      row.item.op = OP_CLEAR;
      add_row(row);
      add_row('{mk_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1, z});
   endtask

   initial begin
      logic [3:0] order_plan[$];
      int unsigned n_terms, n_parts;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 4'd0;
      stall_mode = 0; stall_run = 0; stall_tick = 0;
      cycles = 0; burst_left = 0;
      n_items = 0; n_results = 0; n_mismatch = 0; n_sat = 0; n_full_drops = 0;
      term_count = 0;
      map_order = 4'd1;
      orders_seen[1] = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pass at the reset order, back to back.
      build_directed();
      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed_exp, dir_rows[i].exp);
      // Same table again at order eight (nine and up act as eight).
      write_map_order(4'd8);
      foreach (dir_rows[i]) if (!dir_rows[i].typed_exp) send_item(dir_rows[i].item);

      // Table-full pass: fill past capacity with cheap terms, then a few particles.
      write_map_order(4'd2);
      send_item('{op: OP_CLEAR, default: '0});
      repeat (TABLE_DEPTH + 4) send_random(rand_term(2));
      repeat (3) send_random(rand_particle());

      // Random phases over a spread of orders, extremes included.
      order_plan = '{4'd0, 4'd15, 4'd3, 4'd8, 4'd1, 4'd9, 4'd4, 4'd0, 4'd6, 4'd12, 4'd2, 4'd5};
      foreach (order_plan[p]) begin
         write_map_order(order_plan[p]);
         send_random('{op: OP_CLEAR, default: '0});
         for (int s = 0; s < 12; s++) begin
            if ($urandom_range(0, 3) == 0) send_random('{op: OP_CLEAR, default: '0});
            n_terms = $urandom_range(0, 6);
            n_parts = $urandom_range(1, 4);
            repeat (n_terms) send_random(rand_term(($urandom_range(0, 7) == 0) ? 8 : 3));
            repeat (n_parts) begin
               // occasional noise: unused op or raw random fields
               if ($urandom_range(0, 24) == 0) begin
                  req_type      noise;
                  logic [383:0] raw;
                  raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                  noise = raw[$bits(req_type)-1:0];
                  send_random(noise);
               end
               send_random(rand_particle());
            end
         end
      end

      idle_gap(0);
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d items, %0d mapped particles (%0d saturating), %0d loads dropped",
               n_items, n_results, n_sat, n_full_drops);
      $display("map_order settings exercised: %p, %0d cycles", orders_seen, cycles);
      if (n_mismatch == 0 && mapped_q.size() == 0) begin
         $display("tb_polynomial_map_evaluator_core OK");
      end else begin
         $display("%0d mismatches, %0d results missing", n_mismatch, mapped_q.size());
         $display("tb_polynomial_map_evaluator_core NOT OK");
      end
      $finish;
   end
endmodule
`default_nettype wire
